// ----- rtl/rgbaob_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// shared types and constants of the rgba over-blend core
// no dependencies

package rgbaob_pkg;

    localparam int CH_W = 16;

    // pixel size codes held in the pixel_bytes register
    localparam logic [3:0] PB_8BIT  = 4'd4;
    localparam logic [3:0] PB_16BIT = 4'd8;
    localparam logic [3:0] PB_RESET = PB_8BIT;

    // register index, taken from byte address bit 2
    localparam logic REG_PIXEL_BYTES = 1'b0;

    // channel full scale and its square for both modes
    localparam logic [CH_W-1:0] FULL_8  = 16'h00FF;
    localparam logic [CH_W-1:0] FULL_16 = 16'hFFFF;
    localparam logic [31:0]     SQ_8    = 32'h0000_FE01;
    localparam logic [31:0]     SQ_16   = 32'hFFFE_0001;

    typedef struct packed {
        logic wide;   // 16-bit channels
        logic err;    // unsupported pixel size
    } t_mode;

endpackage

`default_nettype wire

// ----- rtl/rgbaob_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// valid/ready channels for source+destination pixels and blended pixels
// depends on rgbaob_pkg

interface rgbaob_in_if import rgbaob_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] src_red;
    logic [CH_W-1:0] src_green;
    logic [CH_W-1:0] src_blue;
    logic [CH_W-1:0] src_alpha;
    logic [CH_W-1:0] dst_red;
    logic [CH_W-1:0] dst_green;
    logic [CH_W-1:0] dst_blue;
    logic [CH_W-1:0] dst_alpha;
    logic            row_end;

    modport source (
        output valid, src_red, src_green, src_blue, src_alpha,
        output dst_red, dst_green, dst_blue, dst_alpha, row_end,
        input  ready
    );
    modport sink (
        input  valid, src_red, src_green, src_blue, src_alpha,
        input  dst_red, dst_green, dst_blue, dst_alpha, row_end,
        output ready
    );
endinterface

interface rgbaob_out_if import rgbaob_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_alpha;
    logic            row_end_out;
    logic            depth_error;

    modport source (
        output valid, out_red, out_green, out_blue, out_alpha,
        output row_end_out, depth_error,
        input  ready
    );
    modport sink (
        input  valid, out_red, out_green, out_blue, out_alpha,
        input  row_end_out, depth_error,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/rgbaob_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// apb-style register port holding pixel_bytes, decoded into a mode struct
// depends on rgbaob_pkg

module rgbaob_cfg import rgbaob_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output t_mode            o_mode
);

    logic [3:0] r_pixel_bytes;
    logic       w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && (paddr[2] == REG_PIXEL_BYTES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_bytes <= PB_RESET;
        end else if (w_wr) begin
            r_pixel_bytes <= pwdata[3:0];
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == REG_PIXEL_BYTES) begin
            prdata = {28'd0, r_pixel_bytes};
        end
    end

    assign o_mode.wide = (r_pixel_bytes == PB_16BIT);
    assign o_mode.err  = (r_pixel_bytes != PB_8BIT) && (r_pixel_bytes != PB_16BIT);

endmodule

`default_nettype wire

// ----- rtl/rgba_alpha_over_blend_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// rgba over-blend core: five-stage pipeline with apb-style mode register
// depends on rgbaob_pkg, rgbaob_if and rgbaob_cfg
// Usage:
//   i_pix carries one source and one destination RGBA pixel per request;
//   o_pix returns the blended destination pixel, row_end_out and
//   depth_error. A request is taken on valid && ready.
//   pixel_bytes (byte address 0) selects 8-bit (4) or 16-bit (8) channels;
//   any other value gives zero channels with depth_error set.
// Timing:
//   one pixel is accepted every cycle unless o_pix.ready is low and every
//   stage holds a pixel. The depth comes from a masking stage, two multiply
//   stages (source alpha products, then the 32x16 destination product), a
//   wide add stage and the division by full scale squared, done as a shift
//   estimate with a two-step remainder correction.
// Reset and stall:
//   reset empties the pipeline and sets pixel_bytes to 4. When o_pix.ready
//   is low the output holds; stages behind it keep filling bubbles and
//   input ready drops only once every stage holds a pixel. The user must
//   write pixel_bytes only while the pipeline is empty; it is not enforced.

module rgba_alpha_over_blend_core import rgbaob_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    rgbaob_in_if.sink        i_pix,
    rgbaob_out_if.source     o_pix,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int NSTG = 5;

    t_mode w_mode;

    rgbaob_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_mode  (w_mode)
    );

    // stage control
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_adv;

    always_comb begin
        w_adv[NSTG-1] = !r_vld[NSTG-1] || o_pix.ready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            w_adv[i] = !r_vld[i] || w_adv[i+1];
        end
    end

    assign i_pix.ready = w_adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_pix.valid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (w_adv[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    // stage 1: mask channels, form M - sa
    logic [CH_W-1:0] w_mask;
    logic [CH_W-1:0] r1_s [3];
    logic [CH_W-1:0] r1_d [3];
    logic [CH_W-1:0] r1_sa, r1_da, r1_ma;
    t_mode           r1_mode;
    logic            r1_row;

    assign w_mask = w_mode.wide ? FULL_16 : FULL_8;

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r1_s[0] <= i_pix.src_red   & w_mask;
            r1_s[1] <= i_pix.src_green & w_mask;
            r1_s[2] <= i_pix.src_blue  & w_mask;
            r1_d[0] <= i_pix.dst_red   & w_mask;
            r1_d[1] <= i_pix.dst_green & w_mask;
            r1_d[2] <= i_pix.dst_blue  & w_mask;
            r1_sa   <= i_pix.src_alpha & w_mask;
            r1_da   <= i_pix.dst_alpha & w_mask;
            // sa never exceeds the all-ones full scale, so M - sa is an xor
            r1_ma   <= (i_pix.src_alpha & w_mask) ^ w_mask;
            r1_mode <= w_mode;
            r1_row  <= i_pix.row_end;
        end
    end

    // stage 2: sa*s per color and (M-sa)*da
    logic [31:0]     r2_a [3];
    logic [31:0]     r2_b;
    logic [CH_W-1:0] r2_d [3];
    logic [CH_W-1:0] r2_sa;
    t_mode           r2_mode;
    logic            r2_row;

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            for (int c = 0; c < 3; c++) begin
                r2_a[c] <= 32'(r1_sa) * 32'(r1_s[c]);
                r2_d[c] <= r1_d[c];
            end
            r2_b    <= 32'(r1_ma) * 32'(r1_da);
            r2_sa   <= r1_sa;
            r2_mode <= r1_mode;
            r2_row  <= r1_row;
        end
    end

    // stage 3: (M-sa)*da*d, sa*s*M by shift-subtract, alpha division by M
    logic [CH_W-1:0] w_aq0, w_alow, w_afull, w_alpha;
    logic [CH_W:0]   w_arem;
    logic [47:0]     r3_p  [3];
    logic [47:0]     r3_am [3];
    logic [CH_W-1:0] r3_alpha;
    t_mode           r3_mode;
    logic            r3_row;

    always_comb begin
        w_afull = r2_mode.wide ? FULL_16 : FULL_8;
        w_aq0   = r2_mode.wide ? r2_b[31:16] : {8'd0, r2_b[15:8]};
        w_alow  = r2_mode.wide ? r2_b[15:0]  : {8'd0, r2_b[7:0]};
        // y = q0*(M+1) + low, so y - q0*M = low + q0
        w_arem  = 17'(w_alow) + 17'(w_aq0);
        w_alpha = r2_sa + w_aq0 + 16'(w_arem >= 17'(w_afull));
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            for (int c = 0; c < 3; c++) begin
                r3_p[c]  <= 48'(r2_b) * 48'(r2_d[c]);
                r3_am[c] <= r2_mode.wide ? ({r2_a[c], 16'd0} - 48'(r2_a[c]))
                                         : ({8'd0, r2_a[c], 8'd0} - 48'(r2_a[c]));
            end
            r3_alpha <= w_alpha;
            r3_mode  <= r2_mode;
            r3_row   <= r2_row;
        end
    end

    // stage 4: full numerator
    logic [48:0]     r4_x [3];
    logic [CH_W-1:0] r4_alpha;
    t_mode           r4_mode;
    logic            r4_row;

    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            for (int c = 0; c < 3; c++) begin
                r4_x[c] <= 49'(r3_am[c]) + 49'(r3_p[c]);
            end
            r4_alpha <= r3_alpha;
            r4_mode  <= r3_mode;
            r4_row   <= r3_row;
        end
    end

    // stage 5: divide by M^2; shift estimate is low by at most two
    logic [34:0]     w_sq;
    logic [16:0]     w_q0  [3];
    logic [31:0]     w_low [3];
    logic [34:0]     w_r0  [3];
    logic [34:0]     w_rem [3];
    logic            w_ge1 [3];
    logic            w_ge2 [3];
    logic [CH_W-1:0] w_qc  [3];

    always_comb begin
        w_sq = r4_mode.wide ? 35'(SQ_16) : 35'(SQ_8);
        for (int c = 0; c < 3; c++) begin
            w_q0[c]  = r4_mode.wide ? r4_x[c][48:32] : r4_x[c][32:16];
            w_low[c] = r4_mode.wide ? r4_x[c][31:0]  : {16'd0, r4_x[c][15:0]};
            // x - q0*M^2 with M^2 = 2^2k - 2^(k+1) + 1
            w_r0[c]  = 35'(w_low[c])
                     + (r4_mode.wide ? (35'(w_q0[c]) << 17) : (35'(w_q0[c]) << 9))
                     - 35'(w_q0[c]);
            w_ge1[c] = (w_r0[c] >= w_sq);
            w_ge2[c] = (w_r0[c] >= (w_sq << 1));
            w_rem[c] = w_r0[c] - (w_ge2[c] ? (w_sq << 1) : (w_ge1[c] ? w_sq : 35'd0));
            w_qc[c]  = 16'(w_q0[c] + 17'(w_ge1[c]) + 17'(w_ge2[c]));
        end
    end

    logic [CH_W-1:0] r5_c [3];
    logic [CH_W-1:0] r5_alpha;
    logic            r5_err, r5_wide, r5_row;

    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            for (int c = 0; c < 3; c++) begin
                r5_c[c] <= r4_mode.err ? '0 : w_qc[c];
            end
            r5_alpha <= r4_mode.err ? '0 : r4_alpha;
            r5_err   <= r4_mode.err;
            r5_wide  <= r4_mode.wide;
            r5_row   <= r4_row;
        end
    end

    assign o_pix.valid       = r_vld[NSTG-1];
    assign o_pix.out_red     = r5_c[0];
    assign o_pix.out_green   = r5_c[1];
    assign o_pix.out_blue    = r5_c[2];
    assign o_pix.out_alpha   = r5_alpha;
    assign o_pix.row_end_out = r5_row;
    assign o_pix.depth_error = r5_err;

    // checks
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && r5_err) |-> (r5_c[0] == '0 && r5_c[1] == '0 &&
                                     r5_c[2] == '0 && r5_alpha == '0))
        else $error("depth error result not zero");

    a_narrow_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && !r5_err && !r5_wide) |->
            (r5_c[0] <= FULL_8 && r5_c[1] <= FULL_8 &&
             r5_c[2] <= FULL_8 && r5_alpha <= FULL_8))
        else $error("8-bit result above full scale");

    a_rem_fixed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] |-> (w_rem[0] < w_sq && w_rem[1] < w_sq && w_rem[2] < w_sq))
        else $error("division correction out of range");

    a_stage_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[0] && w_adv[1]) |=> r_vld[1])
        else $error("pixel lost between first stages");

endmodule

`default_nettype wire

// ----- dv/rgbaob_blend_checker.sv -----
`timescale 1ns / 1ps
// scoreboard for the rgba over-blend core: follows pixel_bytes writes, predicts
// each blended pixel and compares it with the output requests in order
// depends on rgbaob_pkg and the channel interfaces of rgbaob_if

module rgbaob_blend_checker import rgbaob_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rgbaob_in_if        i_pix,
    rgbaob_out_if       i_res,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_blended,
    output int          o_flagged
);

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
        logic            row_end;
        logic            depth_error;
    } t_blend;

    logic [3:0] pixel_bytes;
    t_blend     blend_q[$];
    int         result_idx;

    // unnormalized over: color is not divided by the output alpha
    function automatic logic [CH_W-1:0] over_colour(input logic [63:0] m, a_s, a_d, s, d);
        logic [63:0] q;
        q = (a_s * s * m + (m - a_s) * a_d * d) / (m * m);
        return q[CH_W-1:0];
    endfunction

    function automatic t_blend blend_pixel(input logic [3:0] pb,
                                           input logic [CH_W-1:0] sr, sg, sb, sa,
                                           input logic [CH_W-1:0] dr, dg, db, da,
                                           input logic re);
        t_blend      r;
        logic [63:0] m;
        logic [63:0] a_s;
        logic [63:0] a_d;
        logic [63:0] q;
        r = '0;
        r.row_end = re;
        if (pb == PB_8BIT) begin
            m = 64'(FULL_8);
        end else if (pb == PB_16BIT) begin
            m = 64'(FULL_16);
        end else begin
            r.depth_error = 1'b1;
            return r;
        end
        // 8-bit mode ignores the upper byte of every channel
        a_s = 64'(sa) & m;
        a_d = 64'(da) & m;
        r.red   = over_colour(m, a_s, a_d, 64'(sr) & m, 64'(dr) & m);
        r.green = over_colour(m, a_s, a_d, 64'(sg) & m, 64'(dg) & m);
        r.blue  = over_colour(m, a_s, a_d, 64'(sb) & m, 64'(db) & m);
        q = a_s + ((m - a_s) * a_d) / m;
        r.alpha = q[CH_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [CH_W-1:0] want, got);
        if (got !== want) begin
            o_fail_count++;
            $display("%0t: pixel %0d %s mismatch, expected %0h, got %0h",
                     $time, result_idx, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_blend want;
        if (!i_rst_n) begin
            pixel_bytes = PB_RESET;
            blend_q.delete();
        end else begin
            // index taken from byte address bit 2, other indexes are ignored
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr[2] == REG_PIXEL_BYTES) begin
                pixel_bytes = i_pwdata[3:0];
            end
            if (i_res.valid && i_res.ready) begin
                if (blend_q.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: pixel %0d unexpected, expected none, got %0h %0h %0h %0h %b %b",
                             $time, result_idx, i_res.out_red, i_res.out_green, i_res.out_blue,
                             i_res.out_alpha, i_res.row_end_out, i_res.depth_error);
                end else begin
                    want = blend_q.pop_front();
                    check_field("red", want.red, i_res.out_red);
                    check_field("green", want.green, i_res.out_green);
                    check_field("blue", want.blue, i_res.out_blue);
                    check_field("alpha", want.alpha, i_res.out_alpha);
                    check_field("row_end_out", 16'(want.row_end), 16'(i_res.row_end_out));
                    check_field("depth_error", 16'(want.depth_error), 16'(i_res.depth_error));
                    if (want.depth_error) begin
                        o_flagged++;
                    end else begin
                        o_blended++;
                    end
                end
                result_idx++;
            end
            if (i_pix.valid && i_pix.ready) begin
                blend_q.push_back(blend_pixel(pixel_bytes,
                    i_pix.src_red, i_pix.src_green, i_pix.src_blue, i_pix.src_alpha,
                    i_pix.dst_red, i_pix.dst_green, i_pix.dst_blue, i_pix.dst_alpha,
                    i_pix.row_end));
            end
        end
        o_pending = blend_q.size();
    end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// top of the rgba over-blend testbench: clock, reset, pixel and register stimulus,
// random backpressure and the verdict
// depends on rgbaob_pkg, rgbaob_if, the core and rgbaob_blend_checker

module tb import rgbaob_pkg::*; ();

    localparam int PIPE_LATENCY = 5;
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int blended;
    int flagged;
    int src_idle_pct;
    int sink_idle_pct;
    int stall_cycles;

    rgbaob_in_if  pix_in ();
    rgbaob_out_if pix_out ();

    rgba_alpha_over_blend_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_in),
        .o_pix   (pix_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    rgbaob_blend_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (pix_in),
        .i_res        (pix_out),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_blended    (blended),
        .o_flagged    (flagged)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // random backpressure on the output channel
    always @(negedge i_clk) begin
        pix_out.ready = ($urandom_range(99) >= sink_idle_pct);
    end

    // watchdog on cycles without any accepted request
    always @(posedge i_clk) begin
        if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no request accepted for %0d cycles", $time, STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_pixel(input logic [CH_W-1:0] sr, sg, sb, sa,
                              input logic [CH_W-1:0] dr, dg, db, da,
                              input logic re);
        while ($urandom_range(99) < src_idle_pct) begin
            pix_in.valid = 1'b0;
            @(negedge i_clk);
        end
        pix_in.valid     = 1'b1;
        pix_in.src_red   = sr;
        pix_in.src_green = sg;
        pix_in.src_blue  = sb;
        pix_in.src_alpha = sa;
        pix_in.dst_red   = dr;
        pix_in.dst_green = dg;
        pix_in.dst_blue  = db;
        pix_in.dst_alpha = da;
        pix_in.row_end   = re;
        do @(posedge i_clk); while (!pix_in.ready);
        @(negedge i_clk);
    endtask

    // biased toward zero and full scale in both channel widths
    function automatic logic [CH_W-1:0] rand_chan();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return {r[15:8], 8'h00};
            3:       return {r[15:8], 8'hFF};
            default: return r[15:0];
        endcase
    endfunction

    task automatic send_random_pixel();
        send_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan(),
                   rand_chan(), rand_chan(), rand_chan(), rand_chan(),
                   1'($urandom_range(1)));
    endtask

    // stop requests and let the pipeline empty before a register write
    task automatic drain();
        pix_in.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (PIPE_LATENCY + 3) @(negedge i_clk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [3:0] value);
        logic [31:0] r;
        r = $urandom;
        drain();
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = {r[31:4], value};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic random_phase(input int src_pct, input int sink_pct);
        logic [3:0] bad;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        reg_write(3'd0, PB_8BIT);
        repeat (PHASE_ITEMS * 9 / 20) send_random_pixel();
        reg_write(3'd0, PB_16BIT);
        repeat (PHASE_ITEMS * 9 / 20) send_random_pixel();
        do bad = 4'($urandom_range(15)); while (bad == PB_8BIT || bad == PB_16BIT);
        reg_write(3'd0, bad);
        repeat (PHASE_ITEMS / 10) send_random_pixel();
    endtask

    initial begin
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        pix_in.valid     = 1'b0;
        pix_in.src_red   = '0;
        pix_in.src_green = '0;
        pix_in.src_blue  = '0;
        pix_in.src_alpha = '0;
        pix_in.dst_red   = '0;
        pix_in.dst_green = '0;
        pix_in.dst_blue  = '0;
        pix_in.dst_alpha = '0;
        pix_in.row_end   = 1'b0;
        pix_out.ready    = 1'b0;
        src_idle_pct     = 0;
        sink_idle_pct    = 0;
        stall_cycles     = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // 8-bit channels straight out of reset
        send_pixel('0, '0, '0, '0, '0, '0, '0, '0, 1'b0);
        send_pixel('1, '1, '1, '1, '1, '1, '1, '1, 1'b1);
        send_pixel(16'h0012, 16'h0080, 16'h00FF, 16'h00FF,
                   16'h0033, 16'h00C0, 16'h0001, 16'h0077, 1'b0);
        send_pixel(16'h00AA, 16'h0055, 16'h00FF, 16'h0000,
                   16'h00FF, 16'h0080, 16'h0010, 16'h00FF, 1'b1);
        send_pixel(16'h00C8, 16'h0020, 16'h0099, 16'h0080,
                   16'h00FF, 16'h0000, 16'h0040, 16'h0000, 1'b0);
        // upper bytes must be ignored
        send_pixel(16'hA5C8, 16'h5A20, 16'hFF99, 16'hAB80,
                   16'h12FF, 16'h3400, 16'hCD40, 16'hEFFF, 1'b1);
        send_pixel(16'hFF00, 16'hFF00, 16'hFF00, 16'hFF00,
                   16'hFF00, 16'hFF00, 16'hFF00, 16'hFF00, 1'b0);

        reg_write(3'd0, PB_16BIT);
        send_pixel('0, '0, '0, '0, '0, '0, '0, '0, 1'b1);
        send_pixel('1, '1, '1, '1, '1, '1, '1, '1, 1'b0);
        send_pixel(16'h1234, 16'h8000, 16'hFFFF, 16'hFFFF,
                   16'h0001, 16'hC000, 16'h7FFF, 16'h4321, 1'b1);
        send_pixel(16'hABCD, 16'h0001, 16'hFFFE, 16'h0000,
                   16'hFFFF, 16'h8001, 16'h00FF, 16'hFFFF, 1'b0);
        send_pixel(16'hFFFF, 16'h0000, 16'h5555, 16'h8000,
                   16'hAAAA, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1);
        send_pixel(16'h0F0F, 16'hF0F0, 16'h00FF, 16'h0001,
                   16'hFF00, 16'h1111, 16'hEEEE, 16'h0000, 1'b0);

        // unsupported pixel sizes at both ends of the register range
        reg_write(3'd0, 4'd0);
        send_pixel('1, '1, '1, '1, '1, '1, '1, '1, 1'b1);
        send_pixel(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0,
                   16'h0FED, 16'hCBA9, 16'h8765, 16'h4321, 1'b0);
        reg_write(3'd0, 4'd15);
        send_pixel('1, '1, '1, '1, '1, '1, '1, '1, 1'b0);
        // write to a register index that does not exist, mode stays in error
        reg_write(3'd4, PB_8BIT);
        send_pixel(16'h0080, 16'h0080, 16'h0080, 16'h0080,
                   16'h0080, 16'h0080, 16'h0080, 16'h0080, 1'b1);

        random_phase(20, 64);
        random_phase(64, 20);
        random_phase(0, 0);

        drain();
        repeat (PIPE_LATENCY * 4) @(negedge i_clk);
        $display("run covered %0d blended pixels in 8-bit and 16-bit modes and %0d flagged",
                 blended, flagged);
        $display("pixel sizes 0, 4, 8, 15 and random bad sizes, three idle profiles");
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
